FILE: sv/refkl_pkg.sv
package refkl_pkg;

	typedef enum logic [1:0] {
		MODE_PRESS   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_CANCEL  = 2'd2,
		MODE_COLLECT = 2'd3
	} mode_t;

	localparam int KEY_W    = 16;
	localparam int IN_EP_W  = 32;
	localparam int S_DATA_W = 56;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 8;

endpackage

FILE: sv/refcounted_key_latch_top.sv
// Per-key hold counter and first-press epoch table held in one synchronous
// memory, one entry per key. Each accepted word is handled in two steps:
// the entry is read in the accept cycle and is modified, written back and
// answered in the execute step after it, so the block takes no new word
// until the last one is answered. A result word that is not yet taken holds
// the block in that execute step until the output is free. After reset and
// after every cancel-all word the table is cleared by a walk over all KEYS
// entries, one entry a cycle, during which s_tready stays low. Every word
// returns one result word; only collect gives nonzero flags.
module refcounted_key_latch_top #(
	parameter int KEYS        = 256,
	parameter int COUNT_WIDTH = 16,
	parameter int EPOCH_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// key[15:0], epoch[47:16], cancelled[48], zero fill
	input  logic [refkl_pkg::S_DATA_W-1:0] s_tdata,
	// mode[1:0]
	input  logic [refkl_pkg::S_USER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// key_down[0], key_pressed[1], zero fill
	output logic [refkl_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int IDX_W   = $clog2(KEYS);
	localparam int ENTRY_W = COUNT_WIDTH + EPOCH_WIDTH;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t                    state_q;
	logic [IDX_W-1:0]          clr_q;
	refkl_pkg::mode_t          mode_q;
	logic [IDX_W-1:0]          idx_q;
	logic [EPOCH_WIDTH-1:0]    epoch_q;
	logic                      cancelled_q;
	logic                      valid_q;
	logic                      m_tvalid_q;
	logic [1:0]                result_q;

	logic [refkl_pkg::KEY_W-1:0]   in_key;
	logic [refkl_pkg::IN_EP_W-1:0] in_epoch;
	logic                          in_valid;
	logic                          accept;
	logic                          out_free;

	logic                      wr_en;
	logic [IDX_W-1:0]          wr_addr;
	logic [ENTRY_W-1:0]        wr_data;
	logic [ENTRY_W-1:0]        rd_data;

	logic [COUNT_WIDTH-1:0]    cnt;
	logic [EPOCH_WIDTH-1:0]    ep_st;
	logic [COUNT_WIDTH-1:0]    new_cnt;
	logic [EPOCH_WIDTH-1:0]    new_ep;
	logic                      upd;
	logic                      edge_hit;
	logic [1:0]                result_d;

	assign in_key   = s_tdata[refkl_pkg::KEY_W-1:0];
	assign in_epoch = s_tdata[refkl_pkg::KEY_W +: refkl_pkg::IN_EP_W];
	assign in_valid = {1'b0, in_key} < (refkl_pkg::KEY_W + 1)'(KEYS);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	refkl_ram #(
		.DEPTH(KEYS),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (accept),
		.rd_addr(in_key[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	assign cnt   = rd_data[COUNT_WIDTH-1:0];
	assign ep_st = rd_data[ENTRY_W-1:COUNT_WIDTH];

	always_comb begin
		new_cnt  = cnt;
		new_ep   = ep_st;
		upd      = 1'b0;
		result_d = 2'b00;
		edge_hit = (epoch_q != '0) && (ep_st == epoch_q);
		case (mode_q)
			refkl_pkg::MODE_PRESS: begin
				upd = valid_q;
				if (cnt == '0) begin
					new_ep = epoch_q;
				end
				if (cnt != '1) begin
					new_cnt = cnt + COUNT_WIDTH'(1);
				end
			end
			refkl_pkg::MODE_RELEASE: begin
				upd     = valid_q && (cnt != '0);
				new_cnt = cnt - COUNT_WIDTH'(1);
				if (cancelled_q && new_cnt == '0) begin
					new_ep = '0;
				end
			end
			refkl_pkg::MODE_COLLECT: begin
				if (valid_q) begin
					result_d = {edge_hit, (cnt != '0) || edge_hit};
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = {new_ep, new_cnt};
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == ST_EXEC && out_free) begin
			wr_en = upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_EXEC && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(KEYS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						if (mode_q == refkl_pkg::MODE_CANCEL) begin
							state_q <= ST_CLEAR;
							clr_q   <= '0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q      <= refkl_pkg::mode_t'(s_tuser[1:0]);
			idx_q       <= in_key[IDX_W-1:0];
			epoch_q     <= EPOCH_WIDTH'(in_epoch);
			cancelled_q <= s_tdata[refkl_pkg::KEY_W + refkl_pkg::IN_EP_W];
			valid_q     <= in_valid;
		end
		if (state_q == ST_EXEC && out_free) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(refkl_pkg::M_DATA_W - 2){1'b0}}, result_q};

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("word accepted while previous one in flight");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_EXEC))
		else $error("result raised outside execute");

	a_noncollect_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC && out_free && mode_q != refkl_pkg::MODE_COLLECT
		|=> m_tdata == '0)
		else $error("nonzero result for non-collect word");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wr_en)
		else $error("table write while idle");

endmodule

FILE: sv/refkl_ram.sv
module refkl_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: verif/refcounted_key_latch_top_tb.sv
module refcounted_key_latch_top_tb;

	localparam int KEYS        = 256;
	localparam int COUNT_WIDTH = 16;
	localparam int EPOCH_WIDTH = 32;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam int N_DIRECTED  = 22;
	localparam int N_RANDOM    = 500;
	localparam int N_SATURATE  = 24;

	typedef struct {
		refkl_pkg::mode_t mode;
		logic [15:0]      key;
		logic [31:0]      epoch;
		logic             cancelled;
		logic             typed;
		logic             down;
		logic             pressed;
	} key_event_t;

	typedef struct {
		logic down;
		logic pressed;
	} key_flags_t;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [refkl_pkg::S_DATA_W-1:0] s_tdata   = '0;
	logic [refkl_pkg::S_USER_W-1:0] s_tuser   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [refkl_pkg::M_DATA_W-1:0] m_tdata;

	logic [COUNT_WIDTH-1:0] held_count [KEYS];
	logic [EPOCH_WIDTH-1:0] first_press_epoch [KEYS];
	key_flags_t             expected_flags [$];
	key_event_t             directed_rows [N_DIRECTED];
	int                     error_count    = 0;
	int                     send_idle_pct  = 0;
	int                     recv_stall_pct = 0;
	logic [31:0]            cur_epoch;

	refcounted_key_latch_top #(
		.KEYS(KEYS),
		.COUNT_WIDTH(COUNT_WIDTH),
		.EPOCH_WIDTH(EPOCH_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("refcounted_key_latch_top: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic key_flags_t latch_predict(input refkl_pkg::mode_t mode,
			input logic [15:0] key, input logic [31:0] epoch, input logic cancelled);
		key_flags_t             flags;
		logic                   in_range;
		logic                   edge_hit;
		logic [EPOCH_WIDTH-1:0] ep;
		flags    = '{1'b0, 1'b0};
		in_range = (key < KEYS);
		ep       = epoch[EPOCH_WIDTH-1:0];
		case (mode)
			refkl_pkg::MODE_PRESS: begin
				if (in_range) begin
					if (held_count[key] == '0)
						first_press_epoch[key] = ep;
					if (held_count[key] != COUNT_MAX)
						held_count[key] = held_count[key] + COUNT_WIDTH'(1);
				end
			end
			refkl_pkg::MODE_RELEASE: begin
				if (in_range && held_count[key] != '0) begin
					held_count[key] = held_count[key] - COUNT_WIDTH'(1);
					if (cancelled && held_count[key] == '0)
						first_press_epoch[key] = '0;
				end
			end
			refkl_pkg::MODE_CANCEL: begin
				for (int i = 0; i < KEYS; i++) begin
					held_count[i]        = '0;
					first_press_epoch[i] = '0;
				end
			end
			default: begin
				if (in_range) begin
					edge_hit      = (ep != '0) && (first_press_epoch[key] == ep);
					flags.down    = (held_count[key] != '0) || edge_hit;
					flags.pressed = edge_hit;
				end
			end
		endcase
		return flags;
	endfunction

	task automatic send_word(input key_event_t ev);
		key_flags_t flags;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, ev.cancelled, ev.epoch, ev.key};
		s_tuser  <= ev.mode;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		flags = latch_predict(ev.mode, ev.key, ev.epoch, ev.cancelled);
		if (ev.typed)
			flags = '{ev.down, ev.pressed};
		expected_flags.push_back(flags);
	endtask

	task automatic send_random_word();
		key_event_t ev;
		int         r;
		r = $urandom_range(99);
		if (r < 2)
			ev.mode = refkl_pkg::MODE_CANCEL;
		else if (r < 38)
			ev.mode = refkl_pkg::MODE_PRESS;
		else if (r < 68)
			ev.mode = refkl_pkg::MODE_RELEASE;
		else
			ev.mode = refkl_pkg::MODE_COLLECT;
		r = $urandom_range(99);
		if (r < 60)
			ev.key = 16'($urandom_range(7));
		else if (r < 75)
			ev.key = 16'($urandom_range(KEYS - 1, KEYS - 8));
		else if (r < 90)
			ev.key = 16'($urandom_range(KEYS - 1));
		else
			ev.key = 16'($urandom);
		if ($urandom_range(9) == 0)
			cur_epoch = cur_epoch + 32'($urandom_range(3, 1));
		r = $urandom_range(99);
		if (r < 70)
			ev.epoch = cur_epoch;
		else if (r < 80)
			ev.epoch = cur_epoch - 32'd1;
		else if (r < 88)
			ev.epoch = '0;
		else
			ev.epoch = $urandom;
		ev.cancelled = 1'($urandom_range(1));
		ev.typed     = 1'b0;
		ev.down      = 1'b0;
		ev.pressed   = 1'b0;
		send_word(ev);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_flags.size() == 0) begin
				$error("result word with nothing pending: %h", m_tdata);
				error_count++;
			end else begin
				if (m_tdata[0] !== expected_flags[0].down) begin
					$error("key_down: expected %0b, got %0b", expected_flags[0].down,
						m_tdata[0]);
					error_count++;
				end
				if (m_tdata[1] !== expected_flags[0].pressed) begin
					$error("key_pressed: expected %0b, got %0b", expected_flags[0].pressed,
						m_tdata[1]);
					error_count++;
				end
				void'(expected_flags.pop_front());
			end
		end
	end

	initial begin
		key_event_t ev;
		int         drain;
		directed_rows = '{
			'{refkl_pkg::MODE_COLLECT, 16'd0,    32'd1,         1'b0, 1'b1, 1'b0, 1'b0},
			'{refkl_pkg::MODE_PRESS,   16'd0,    32'd5,         1'b0, 1'b1, 1'b0, 1'b0},
			'{refkl_pkg::MODE_COLLECT, 16'd0,    32'd5,         1'b0, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_COLLECT, 16'd0,    32'd6,         1'b0, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_RELEASE, 16'd0,    32'd0,         1'b0, 1'b1, 1'b0, 1'b0},
			'{refkl_pkg::MODE_COLLECT, 16'd0,    32'd5,         1'b0, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_PRESS,   16'd0,    32'd7,         1'b0, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_RELEASE, 16'd0,    32'd7,         1'b1, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_COLLECT, 16'd0,    32'd7,         1'b0, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_RELEASE, 16'd0,    32'd7,         1'b1, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_PRESS,   16'd255,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_COLLECT, 16'd255,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1},
			'{refkl_pkg::MODE_PRESS,   16'd256,  32'd1,         1'b0, 1'b1, 1'b0, 1'b0},
			'{refkl_pkg::MODE_COLLECT, 16'd256,  32'd1,         1'b0, 1'b1, 1'b0, 1'b0},
			'{refkl_pkg::MODE_COLLECT, 16'hFFFF, 32'd0,         1'b1, 1'b1, 1'b0, 1'b0},
			'{refkl_pkg::MODE_PRESS,   16'd1,    32'd0,         1'b0, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_COLLECT, 16'd1,    32'd0,         1'b0, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_PRESS,   16'd255,  32'd3,         1'b0, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_COLLECT, 16'd255,  32'd3,         1'b0, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_CANCEL,  16'hAAAA, 32'h5555_5555, 1'b1, 1'b1, 1'b0, 1'b0},
			'{refkl_pkg::MODE_COLLECT, 16'd255,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0},
			'{refkl_pkg::MODE_COLLECT, 16'd1,    32'd0,         1'b0, 1'b0, 1'b0, 1'b0}
		};
		cur_epoch = $urandom;
		for (int i = 0; i < KEYS; i++) begin
			held_count[i]        = '0;
			first_press_epoch[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(directed_rows[i]);

		// press one key repeatedly, then query, release, query again and cancel all
		ev = '{refkl_pkg::MODE_PRESS, 16'd2, 32'd9, 1'b0, 1'b0, 1'b0, 1'b0};
		for (int i = 0; i < N_SATURATE; i++)
			send_word(ev);
		ev.mode = refkl_pkg::MODE_COLLECT;
		send_word(ev);
		ev.mode = refkl_pkg::MODE_RELEASE;
		send_word(ev);
		ev.mode = refkl_pkg::MODE_COLLECT;
		send_word(ev);
		ev.mode = refkl_pkg::MODE_CANCEL;
		send_word(ev);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			for (int i = 0; i < N_RANDOM; i++)
				send_random_word();
		end
		s_tvalid <= 1'b0;
		recv_stall_pct = 0;

		drain = 0;
		while (expected_flags.size() != 0 && drain < 100_000) begin
			@(posedge clk);
			drain++;
		end
		repeat (16) @(posedge clk);
		if (expected_flags.size() != 0) begin
			$error("%0d result words never arrived", expected_flags.size());
			error_count++;
		end
		if (error_count == 0)
			$display("refcounted_key_latch_top: match");
		else
			$display("refcounted_key_latch_top: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
sv/refkl_pkg.sv
sv/refkl_ram.sv
sv/refcounted_key_latch_top.sv
verif/refcounted_key_latch_top_tb.sv
